// ===== rtl/simplified_aes_cipher_defines.svh =====
// Assertion macros shared by the simplified AES cipher RTL.
`ifndef SIMPLIFIED_AES_CIPHER_DEFINES_SVH
`define SIMPLIFIED_AES_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define SAC_ASSERT_SAME(lbl, ante, cons)
`define SAC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/sac_pkg.sv =====
// Types, constants and nibble-level functions for the simplified AES cipher.
package sac_pkg;

  localparam int unsigned BLOCK_W = 16;
  localparam int unsigned KEY_W   = 16;

  // Operation codes carried in the transaction's user field.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Round constants of the key schedule.
  localparam logic [7:0] RCON_1 = 8'h80;
  localparam logic [7:0] RCON_2 = 8'h30;

  // Mix column matrices: forward [1 4; 4 1], inverse [9 2; 2 9].
  localparam logic [3:0] MIX_FWD_DIAG = 4'h1;
  localparam logic [3:0] MIX_FWD_OFF  = 4'h4;
  localparam logic [3:0] MIX_INV_DIAG = 4'h9;
  localparam logic [3:0] MIX_INV_OFF  = 4'h2;

  typedef logic [BLOCK_W-1:0] block_t;

  // The three round keys expanded from the cipher key.
  typedef struct packed {
    block_t k0;
    block_t k1;
    block_t k2;
  } round_keys_t;

  // Forward nibble substitution.
  function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
    logic [3:0] r;
    unique case (n)
      4'h0: r = 4'h9;
      4'h1: r = 4'h4;
      4'h2: r = 4'hA;
      4'h3: r = 4'hB;
      4'h4: r = 4'hD;
      4'h5: r = 4'h1;
      4'h6: r = 4'h8;
      4'h7: r = 4'h5;
      4'h8: r = 4'h6;
      4'h9: r = 4'h2;
      4'hA: r = 4'h0;
      4'hB: r = 4'h3;
      4'hC: r = 4'hC;
      4'hD: r = 4'hE;
      4'hE: r = 4'hF;
      default: r = 4'h7;
    endcase
    return r;
  endfunction

  // Inverse nibble substitution.
  function automatic logic [3:0] sbox_inv(input logic [3:0] n);
    logic [3:0] r;
    unique case (n)
      4'h0: r = 4'hA;
      4'h1: r = 4'h5;
      4'h2: r = 4'h9;
      4'h3: r = 4'hB;
      4'h4: r = 4'h1;
      4'h5: r = 4'h7;
      4'h6: r = 4'h8;
      4'h7: r = 4'hF;
      4'h8: r = 4'h6;
      4'h9: r = 4'h0;
      4'hA: r = 4'h2;
      4'hB: r = 4'h3;
      4'hC: r = 4'hC;
      4'hD: r = 4'h4;
      4'hE: r = 4'hD;
      default: r = 4'hE;
    endcase
    return r;
  endfunction

  // Multiply in GF(2^4) modulo x^4 + x + 1.
  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] r;
    logic [3:0] aa;
    logic [3:0] bb;
    r  = 4'h0;
    aa = a;
    bb = b;
    for (int i = 0; i < 4; i++) begin
      if (bb[0]) begin
        r = r ^ aa;
      end
      bb = bb >> 1;
      aa = aa[3] ? ({aa[2:0], 1'b0} ^ 4'h3) : {aa[2:0], 1'b0};
    end
    return r;
  endfunction

  // Substitute all four nibbles of a block.
  function automatic block_t sub_fwd(input block_t s);
    return {sbox_fwd(s[15:12]), sbox_fwd(s[11:8]), sbox_fwd(s[7:4]), sbox_fwd(s[3:0])};
  endfunction

  function automatic block_t sub_inv(input block_t s);
    return {sbox_inv(s[15:12]), sbox_inv(s[11:8]), sbox_inv(s[7:4]), sbox_inv(s[3:0])};
  endfunction

  // Row 1 holds nibbles 1 and 3; shifting it swaps them. It is its own inverse.
  function automatic block_t shift_rows(input block_t s);
    return {s[15:12], s[3:0], s[7:4], s[11:8]};
  endfunction

  // Multiply both columns by the matrix [diag off; off diag].
  function automatic block_t mix_cols(input block_t s, input logic [3:0] diag,
                                      input logic [3:0] off);
    return {gf_mul(diag, s[15:12]) ^ gf_mul(off, s[11:8]),
            gf_mul(off, s[15:12])  ^ gf_mul(diag, s[11:8]),
            gf_mul(diag, s[7:4])   ^ gf_mul(off, s[3:0]),
            gf_mul(off, s[7:4])    ^ gf_mul(diag, s[3:0])};
  endfunction

  // Key schedule g function: rotate nibbles, substitute, add round constant.
  function automatic logic [7:0] key_g(input logic [7:0] w, input logic [7:0] rc);
    return {sbox_fwd(w[3:0]), sbox_fwd(w[7:4])} ^ rc;
  endfunction

  // Expand a cipher key into K0, K1 and K2.
  function automatic round_keys_t expand_key(input logic [KEY_W-1:0] key);
    round_keys_t rk;
    logic [7:0]  w2;
    logic [7:0]  w3;
    logic [7:0]  w4;
    logic [7:0]  w5;
    w2 = key[15:8] ^ key_g(key[7:0], RCON_1);
    w3 = w2 ^ key[7:0];
    w4 = w2 ^ key_g(w3, RCON_2);
    w5 = w4 ^ w3;
    rk.k0 = key;
    rk.k1 = {w2, w3};
    rk.k2 = {w4, w5};
    return rk;
  endfunction

endpackage

// ===== rtl/simplified_aes_cipher.sv =====
// Top level of the simplified AES block cipher with a two-register pipeline.
//
//  Channel  Direction  Ports                    Contents
//  in       slave      in_tvalid/tready/tdata   tdata: block_in; tuser: op
//  out      master     out_tvalid/tready/tdata  tdata: block_out
//  cfg      write-only cfg_wen/cfg_wdata        16-bit cipher key
//
// Each transaction is held in the input register, passes through the whole
// cipher, and is then captured in the result register.
// A new transaction can be accepted every cycle; only a stall at the output
// holds the pipeline. Round keys are expanded and registered on a key write.
// Reset (rst_n low, synchronous) empties the pipeline and sets the key to 0.
module simplified_aes_cipher (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [sac_pkg::BLOCK_W-1:0] in_tdata,   // [15:0] block_in
  input  logic                      in_tuser,     // [0] op
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [sac_pkg::BLOCK_W-1:0] out_tdata,  // [15:0] block_out
  input  logic                      cfg_wen,
  input  logic [sac_pkg::KEY_W-1:0] cfg_wdata
);
  import sac_pkg::*;

  `include "simplified_aes_cipher_defines.svh"

  round_keys_t rk_r;
  logic        s1_valid_r;
  logic        s1_op_r;
  block_t      s1_block_r;
  logic        out_valid_r;
  block_t      out_block_r;
  logic        s1_adv;
  logic        in_acc;
  block_t      enc_r1;
  block_t      enc_res;
  block_t      dec_r1;
  block_t      dec_res;
  block_t      result;

  // Handshake: stage 1 moves on when the result register is free or drained.
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Round keys are expanded once, when the key is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r <= expand_key('0);
    end else if (cfg_wen) begin
      rk_r <= expand_key(cfg_wdata);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_tuser;
      s1_block_r <= in_tdata;
    end
  end

  // Encryption: add K0, full round with K1, final round with K2.
  always_comb begin
    enc_r1  = mix_cols(shift_rows(sub_fwd(s1_block_r ^ rk_r.k0)), MIX_FWD_DIAG,
                       MIX_FWD_OFF) ^ rk_r.k1;
    enc_res = shift_rows(sub_fwd(enc_r1)) ^ rk_r.k2;
  end

  // Decryption: the inverse steps in reverse order.
  always_comb begin
    dec_r1  = mix_cols(sub_inv(shift_rows(s1_block_r ^ rk_r.k2)) ^ rk_r.k1,
                       MIX_INV_DIAG, MIX_INV_OFF);
    dec_res = sub_inv(shift_rows(dec_r1)) ^ rk_r.k0;
  end

  assign result = (s1_op_r == OP_DECRYPT) ? dec_res : enc_res;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_block_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_block_r;

  // A transaction accepted at the input sits in the input register next cycle.
  `SAC_ASSERT_NEXT(a_in_to_s1, in_acc, s1_valid_r)
  // An item leaving the input register lands in the result register.
  `SAC_ASSERT_NEXT(a_s1_to_out, s1_valid_r && s1_adv, out_valid_r)
  // An empty pipeline never back-pressures the input.
  `SAC_ASSERT_SAME(a_empty_ready, !s1_valid_r && !out_valid_r, in_tready)
  // The round keys follow the last written key.
  `SAC_ASSERT_NEXT(a_key_write, cfg_wen, rk_r == expand_key($past(cfg_wdata)))
  // An input stall only happens while the result register is held.
  `SAC_ASSERT_SAME(a_stall_cause, !in_tready, out_valid_r && !out_tready)

endmodule

// ===== sim/simplified_aes_cipher_tb.sv =====
// Self-checking testbench for the simplified AES cipher with its own cipher model.
module simplified_aes_cipher_tb;

  import sac_pkg::*;

  // Substitution tables, entry n held in bits [4n+3:4n].
  localparam logic [63:0] SUB_FWD_TBL = 64'h7FEC_3026_581D_BA49;
  localparam logic [63:0] SUB_INV_TBL = 64'hED4C_3206_F871_B95A;

  // Idle modes that the phases rotate through.
  localparam int MODE_NONE   = 0;
  localparam int MODE_SEND   = 1;
  localparam int MODE_STALL  = 2;
  localparam int MODE_BOTH   = 3;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic         op;
    logic [15:0]  blk;
  } cipher_req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] block_in
  logic        in_tuser;   // [0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] block_out
  logic        cfg_wen;
  logic [15:0] cfg_wdata;

  cipher_req_t block_jobs[$];
  logic [15:0] block_out_due[$];
  logic [15:0] key_model;
  int          send_idle_pct;
  int          stall_pct;
  int          error_count;

  simplified_aes_cipher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Substitute all four nibbles through the forward or inverse table.
  function automatic logic [15:0] sub_all(input logic [15:0] s, input bit inv);
    logic [63:0] tbl;
    logic [15:0] r;
    tbl = inv ? SUB_INV_TBL : SUB_FWD_TBL;
    for (int i = 0; i < 4; i++) begin
      r[4*i +: 4] = tbl[4*int'(s[4*i +: 4]) +: 4];
    end
    return r;
  endfunction

  // Row 1 is nibbles 1 and 3; shifting it swaps them.
  function automatic logic [15:0] swap_row1(input logic [15:0] s);
    return {s[15:12], s[3:0], s[7:4], s[11:8]};
  endfunction

  // Product in GF(2^4) modulo x^4 + x + 1.
  function automatic logic [3:0] gf4_mult(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] acc;
    logic [3:0] x;
    acc = 4'h0;
    x   = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
    end
    return acc;
  endfunction

  // Multiply each column by [diag off; off diag].
  function automatic logic [15:0] column_mix(input logic [15:0] s, input logic [3:0] diag,
                                             input logic [3:0] off);
    logic [15:0] r;
    logic [3:0]  top;
    logic [3:0]  bot;
    for (int c = 0; c < 2; c++) begin
      top = s[12 - 8*c +: 4];
      bot = s[8 - 8*c +: 4];
      r[12 - 8*c +: 4] = gf4_mult(diag, top) ^ gf4_mult(off, bot);
      r[8 - 8*c +: 4]  = gf4_mult(off, top) ^ gf4_mult(diag, bot);
    end
    return r;
  endfunction

  // Key schedule step: swap the nibbles, substitute them, add the round constant.
  function automatic logic [7:0] sched_g(input logic [7:0] w, input logic [7:0] rc);
    logic [15:0] t;
    t = sub_all({8'h00, w[3:0], w[7:4]}, 1'b0);
    return t[7:0] ^ rc;
  endfunction

  // Expected block for one transaction under the given key.
  function automatic logic [15:0] saes_transform(input logic op, input logic [15:0] key,
                                                 input logic [15:0] blk);
    logic [7:0]  w2;
    logic [7:0]  w3;
    logic [7:0]  w4;
    logic [7:0]  w5;
    logic [15:0] k1;
    logic [15:0] k2;
    logic [15:0] s;
    w2 = key[15:8] ^ sched_g(key[7:0], RCON_1);
    w3 = w2 ^ key[7:0];
    w4 = w2 ^ sched_g(w3, RCON_2);
    w5 = w4 ^ w3;
    k1 = {w2, w3};
    k2 = {w4, w5};
    if (op == OP_ENCRYPT) begin
      s = blk ^ key;
      s = column_mix(swap_row1(sub_all(s, 1'b0)), MIX_FWD_DIAG, MIX_FWD_OFF) ^ k1;
      s = swap_row1(sub_all(s, 1'b0)) ^ k2;
    end else begin
      s = blk ^ k2;
      s = sub_all(swap_row1(s), 1'b1) ^ k1;
      s = column_mix(s, MIX_INV_DIAG, MIX_INV_OFF);
      s = sub_all(swap_row1(s), 1'b1) ^ key;
    end
    return s;
  endfunction

  // Input side: record each accepted transaction, then offer the next one or idle.
  always @(posedge clk) begin
    cipher_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        block_out_due = {block_out_due, saes_transform(in_tuser, key_model, in_tdata)};
      end
      if (!in_tvalid || in_tready) begin
        if (block_jobs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = block_jobs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.blk;
          in_tuser  <= nxt.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (block_out_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          error_count++;
        end else begin
          want = block_out_due.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: block_out mismatch, expected %h, actual %h",
                     $time, want, out_tdata);
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Wait until every queued transaction has been accepted and its result seen.
  // The check runs at the falling edge, after all rising-edge updates settled.
  task automatic drain();
    while (block_jobs.size() != 0 || in_tvalid || block_out_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Load a new cipher key while the pipeline is empty.
  task automatic write_key(input logic [15:0] k);
    drain();
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    key_model = k;
    // Let the registered round keys settle before new traffic.
    repeat (3) @(posedge clk);
  endtask

  task automatic push_job(input logic op, input logic [15:0] blk);
    cipher_req_t r;
    r.op  = op;
    r.blk = blk;
    block_jobs = {block_jobs, r};
  endtask

  // Stimulus: directed vectors, then random phases over keys and idle modes.
  initial begin
    int          count;
    int          mode;
    logic [15:0] p;
    logic [15:0] k;
    logic        op;
    error_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    key_model     = 16'h0000;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 16'h0000;
    in_tuser      = 1'b0;
    out_tready    = 1'b0;
    cfg_wen       = 1'b0;
    cfg_wdata     = 16'h0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Under the reset key: field extremes and nibble patterns, both operations.
    push_job(OP_ENCRYPT, 16'h0000);
    push_job(OP_DECRYPT, 16'h0000);
    push_job(OP_ENCRYPT, 16'hFFFF);
    push_job(OP_DECRYPT, 16'hFFFF);
    push_job(OP_ENCRYPT, 16'hAAAA);
    push_job(OP_DECRYPT, 16'h5555);
    push_job(OP_ENCRYPT, 16'h0F0F);
    push_job(OP_DECRYPT, 16'hF0F0);
    push_job(OP_ENCRYPT, 16'h1234);
    push_job(OP_DECRYPT, 16'hFEDC);

    // Textbook key and block, plus its ciphertext back through decryption.
    write_key(16'h4AF5);
    push_job(OP_ENCRYPT, 16'hD728);
    push_job(OP_DECRYPT, 16'h24EC);
    push_job(OP_ENCRYPT, 16'h0000);
    push_job(OP_DECRYPT, 16'hFFFF);

    // Key extremes.
    write_key(16'hFFFF);
    push_job(OP_ENCRYPT, 16'h8001);
    push_job(OP_DECRYPT, 16'h7FFE);
    write_key(16'h0000);
    push_job(OP_ENCRYPT, 16'hC3A5);
    push_job(OP_DECRYPT, 16'h5A3C);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        k = 16'hFFFF;
      end else if (phase == 4) begin
        k = 16'h0000;
      end else begin
        k = 16'($urandom());
      end
      write_key(k);
      mode = phase % 4;
      send_idle_pct = (mode == MODE_NONE) ? 0 : (mode == MODE_SEND) ? 85 :
                      (mode == MODE_BOTH) ? 19 : 0;
      stall_pct     = (mode == MODE_NONE) ? 0 : (mode == MODE_STALL) ? 85 :
                      (mode == MODE_BOTH) ? 19 : 0;
      count = 0;
      while (count < PHASE_ITEMS) begin
        p  = 16'($urandom());
        op = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 6) begin
          // Round trip: a block followed by its own transform in the other direction.
          push_job(op, p);
          push_job(~op, saes_transform(op, key_model, p));
          count += 2;
        end else begin
          push_job(op, p);
          count++;
        end
      end
    end

    drain();
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("simplified_aes_cipher verification clean");
    end else begin
      $display("simplified_aes_cipher verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("simplified_aes_cipher verification failed");
    $finish;
  end

endmodule
